/* rtl/core/rrd_pkg.sv */
// Shared types and constants for the round-robin ready-list distributor.
// No dependencies; imported by every module of the block.
package rrd_pkg;

    localparam int MAX_PORTS = 16;
    localparam int IDX_W     = $clog2(MAX_PORTS);
    localparam int CNT_W     = $clog2(MAX_PORTS + 1);
    localparam int PORT_W    = 4;
    localparam int STAT_W    = 2;

    typedef logic [PORT_W-1:0] t_port;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_READY = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic {
        FN_READY = 1'b0,
        FN_SEND  = 1'b1
    } t_func;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_ctrl_cmd;

endpackage

/* rtl/core/rrd_ctrl.sv */
// Controller state machine for the distributor: capture, execute, done strobe.
// Depends on rrd_pkg.
module rrd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic              o_done,
    output rrd_pkg::t_ctrl_cmd o_cmd
);
    import rrd_pkg::*;

    t_state r_state, n_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.execute;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

/* rtl/core/rrd_dpath.sv */
// Datapath: ready list, entry count, current position and result registers.
// Depends on rrd_pkg; driven by rrd_ctrl commands.
module rrd_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rrd_pkg::t_ctrl_cmd i_cmd,
    input  logic               i_func,
    input  rrd_pkg::t_port     i_port_id,
    input  logic               i_release_req,
    output rrd_pkg::t_status   o_status,
    output rrd_pkg::t_port     o_target_port,
    output logic               o_was_empty
);
    import rrd_pkg::*;

    // captured beat
    t_func   r_func;
    t_port   r_port_id;
    logic    r_release;

    // list state
    t_port   r_list [MAX_PORTS];
    t_cnt    r_count, n_count;
    t_idx    r_cur, n_cur;

    // results
    t_status r_status, n_status;
    t_port   r_target, n_target;
    logic    r_was_empty, n_was_empty;

    t_idx    cur_eff;
    t_cnt    cur_ext;
    t_cnt    adv;
    t_cnt    limit;
    logic    list_empty;
    logic    list_full;
    logic    do_append;
    logic    do_erase;

    assign list_empty = (r_count == '0);
    assign list_full  = (r_count == CNT_W'(MAX_PORTS));
    // current position wraps to head if it ever sits past the tail
    assign cur_eff    = (CNT_W'(r_cur) >= r_count) ? '0 : r_cur;
    assign cur_ext    = CNT_W'(cur_eff);

    always_comb begin
        n_count     = r_count;
        n_cur       = r_cur;
        n_status    = ST_OK;
        n_target    = '0;
        n_was_empty = 1'b0;
        do_append   = 1'b0;
        do_erase    = 1'b0;
        adv         = cur_ext;
        limit       = r_count;
        unique case (r_func)
            FN_READY: begin
                if (list_full) begin
                    n_status = ST_FULL;
                end else begin
                    do_append   = 1'b1;
                    n_was_empty = list_empty;
                    n_count     = r_count + CNT_W'(1);
                    if (list_empty) n_cur = '0;
                end
            end
            FN_SEND: begin
                if (list_empty) begin
                    n_status = ST_NO_READY;
                end else begin
                    n_target = r_list[cur_eff];
                    if (r_release) begin
                        do_erase = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                        limit    = r_count - CNT_W'(1);
                    end else begin
                        adv = cur_ext + CNT_W'(1);
                    end
                    n_cur = (adv >= limit) ? '0 : adv[IDX_W-1:0];
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cur   <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
            r_cur   <= n_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= t_func'(i_func);
            r_port_id <= i_port_id;
            r_release <= i_release_req;
        end
        if (i_cmd.execute) begin
            r_status    <= n_status;
            r_target    <= n_target;
            r_was_empty <= n_was_empty;
        end
    end

    // list storage: append at tail, erase shifts the upper part down
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && do_append) begin
            r_list[r_count[IDX_W-1:0]] <= r_port_id;
        end
        if (i_cmd.execute && do_erase) begin
            for (int i = 0; i < MAX_PORTS - 1; i++) begin
                if (IDX_W'(i) >= cur_eff) r_list[IDX_W'(i)] <= r_list[IDX_W'(i + 1)];
            end
        end
    end

    assign o_status      = r_status;
    assign o_target_port = r_target;
    assign o_was_empty   = r_was_empty;

endmodule

/* rtl/core/round_robin_ready_list_distributor_core.sv */
// Top level of the round-robin ready-list distributor.
// Depends on rrd_pkg, rrd_ctrl and rrd_dpath.
//
// Usage:
//   Command channel: drive i_func, i_port_id, i_release_req and raise
//   i_start; the beat is taken at the clock edge where i_start is high and
//   o_busy is low. i_func = 0 appends i_port_id to the tail of the ready
//   list; i_func = 1 sends to the current port and advances round-robin,
//   erasing that entry first when i_release_req is set.
//   Result channel: o_done pulses for exactly one cycle with o_status,
//   o_target_port and o_was_empty valid in that cycle. The receiver cannot
//   stall; each result must be taken in its strobe cycle.
//   Timing: the result strobe is high in the cycle that follows the
//   execute cycle. A new beat is taken only while the controller is idle,
//   so each beat runs through its capture and execute states before the
//   next; a new beat may be accepted in the same cycle that the previous
//   result is strobed.
//   The erase shifts the later list entries down in parallel in the execute cycle.
//   Reset (synchronous, active low): list empty, current position at the
//   head, controller idle, no strobe. List entries need no clearing; only
//   entries below the count ever reach the outputs.
module round_robin_ready_list_distributor_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic                       i_func,
    input  logic [rrd_pkg::PORT_W-1:0] i_port_id,
    input  logic                       i_release_req,
    output logic                       o_done,
    output logic [rrd_pkg::STAT_W-1:0] o_status,
    output logic [rrd_pkg::PORT_W-1:0] o_target_port,
    output logic                       o_was_empty
);
    import rrd_pkg::*;

    t_ctrl_cmd ctrl_cmd;
    t_status   dp_status;

    rrd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_cmd   (ctrl_cmd)
    );

    rrd_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_func        (i_func),
        .i_port_id     (i_port_id),
        .i_release_req (i_release_req),
        .o_status      (dp_status),
        .o_target_port (o_target_port),
        .o_was_empty   (o_was_empty)
    );

    assign o_status = STAT_W'(dp_status);

endmodule

/* verif/rrd_dispatch_checker.sv */
// Checker for the round-robin ready-list distributor: tracks the ready list,
// predicts every result and compares it with the result strobe.
// Depends on rrd_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module rrd_dispatch_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic                       i_func,
    input  logic [rrd_pkg::PORT_W-1:0] i_port_id,
    input  logic                       i_release_req,
    input  logic                       i_done,
    input  logic [rrd_pkg::STAT_W-1:0] i_status,
    input  logic [rrd_pkg::PORT_W-1:0] i_target_port,
    input  logic                       i_was_empty,
    output int                         o_pending,
    output int                         o_err_count
);
    import rrd_pkg::*;

    typedef struct packed {
        t_status status;
        t_port   target;
        logic    was_empty;
    } t_dispatch;

    t_port     ready_ports [MAX_PORTS];
    t_cnt      port_count;
    t_cnt      serve_pos;
    t_dispatch dispatch_q[$];

    // Applies one command to the tracked list and returns the expected result.
    function automatic t_dispatch predict_dispatch(input t_func fn, input t_port port,
                                                   input logic rel);
        t_dispatch r;
        r = '{status: ST_OK, target: '0, was_empty: 1'b0};
        if (fn == FN_READY) begin
            if (port_count >= MAX_PORTS) begin
                r.status = ST_FULL;
            end else begin
                r.was_empty = (port_count == 0);
                if (r.was_empty) serve_pos = '0;
                ready_ports[port_count] = port;
                port_count++;
            end
        end else if (port_count == 0) begin
            r.status = ST_NO_READY;
        end else begin
            if (serve_pos >= port_count) serve_pos = '0;
            r.target = ready_ports[serve_pos];
            if (rel) begin
                // erase current entry, later entries slide down
                for (int i = serve_pos; i + 1 < port_count; i++)
                    ready_ports[i] = ready_ports[i+1];
                port_count--;
            end else begin
                serve_pos++;
            end
            if (serve_pos >= port_count) serve_pos = '0;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dispatch exp_r;
        if (!i_rst_n) begin
            port_count = '0;
            serve_pos  = '0;
            dispatch_q.delete();
            o_err_count <= 0;
        end else begin
            // results first: a beat accepted at this edge cannot be strobed yet
            if (i_done) begin
                if (dispatch_q.size() == 0) begin
                    $display("%0t: result with nothing expected: status %0d port %0d empty %0b",
                             $time, i_status, i_target_port, i_was_empty);
                    o_err_count <= o_err_count + 1;
                end else begin
                    exp_r = dispatch_q.pop_front();
                    if (i_status !== exp_r.status || i_target_port !== exp_r.target ||
                        i_was_empty !== exp_r.was_empty) begin
                        if (i_status !== exp_r.status)
                            $display("%0t: status mismatch: expected %0d actual %0d",
                                     $time, exp_r.status, i_status);
                        if (i_target_port !== exp_r.target)
                            $display("%0t: target_port mismatch: expected %0d actual %0d",
                                     $time, exp_r.target, i_target_port);
                        if (i_was_empty !== exp_r.was_empty)
                            $display("%0t: was_empty mismatch: expected %0b actual %0b",
                                     $time, exp_r.was_empty, i_was_empty);
                        o_err_count <= o_err_count + 1;
                    end
                end
            end
            if (i_start && !i_busy)
                dispatch_q.push_back(predict_dispatch(t_func'(i_func), i_port_id,
                                                      i_release_req));
        end
        o_pending <= dispatch_q.size();
    end

    initial begin
        o_pending   = 0;
        o_err_count = 0;
        port_count  = '0;
        serve_pos   = '0;
    end

endmodule

/* verif/tb_round_robin_ready_list_distributor_core.sv */
// Testbench top for the round-robin ready-list distributor core.
// Drives directed and random command beats; rrd_dispatch_checker predicts and
// compares the results. Depends on rrd_pkg, the core and the checker.
`timescale 1ns / 1ps

module tb_round_robin_ready_list_distributor_core;
    import rrd_pkg::*;

    localparam int N_RANDOM    = 450;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_start;
    logic          o_busy;
    logic          i_func;
    t_port         i_port_id;
    logic          i_release_req;
    logic          o_done;
    logic [STAT_W-1:0] o_status;
    t_port         o_target_port;
    logic          o_was_empty;

    int pending;
    int err_count;
    int cycle_cnt;

    // idle gap behavior for the current stretch of random beats
    bit no_idle;

    round_robin_ready_list_distributor_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_func        (i_func),
        .i_port_id     (i_port_id),
        .i_release_req (i_release_req),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_target_port (o_target_port),
        .o_was_empty   (o_was_empty)
    );

    rrd_dispatch_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_busy        (o_busy),
        .i_func        (i_func),
        .i_port_id     (i_port_id),
        .i_release_req (i_release_req),
        .i_done        (o_done),
        .i_status      (o_status),
        .i_target_port (o_target_port),
        .i_was_empty   (o_was_empty),
        .o_pending     (pending),
        .o_err_count   (err_count)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending);
            $display("tb_round_robin_ready_list_distributor_core: done, errors");
            $finish;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one beat and holds it until the core takes it. Called right
    // after a rising edge; returns right after the accepting edge. start is
    // only lowered for a real gap, so back-to-back beats keep it high.
    task automatic issue_beat(input t_func fn, input t_port port, input logic rel,
                              input int gap);
        i_start       <= 1'b1;
        i_func        <= fn;
        i_port_id     <= port;
        i_release_req <= rel;
        do @(posedge i_clk); while (o_busy);
        if (gap > 0) begin
            // park the fields on junk while idle; the core must ignore them
            i_start       <= 1'b0;
            i_func        <= 1'($urandom_range(0, 1));
            i_port_id     <= t_port'($urandom_range(0, 15));
            i_release_req <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Holds off until every result so far has been strobed. pending is registered
    // behind the edge, hence the first wait is unconditional.
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int app_pct;
        int rel_pct;
        cycle_cnt     = 0;
        no_idle       = 1'b0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_func        = FN_READY;
        i_port_id     = '0;
        i_release_req = 1'b0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed beats ----------------
        // send on an empty list straight out of reset
        issue_beat(FN_SEND, 4'd7, 1'b0, pick_gap());
        // first append reports was_empty; release_req is ignored for appends
        issue_beat(FN_READY, 4'd0, 1'b1, pick_gap());
        // erase the only entry: list empties, position back to the head
        issue_beat(FN_SEND, 4'd15, 1'b1, pick_gap());
        issue_beat(FN_SEND, 4'd0, 1'b1, pick_gap());
        // top port id, then a duplicate held twice
        issue_beat(FN_READY, 4'd15, 1'b0, pick_gap());
        issue_beat(FN_READY, 4'd9, 1'b0, pick_gap());
        issue_beat(FN_READY, 4'd9, 1'b1, pick_gap());
        // four sends over three entries: wraps tail to head
        repeat (4) issue_beat(FN_SEND, t_port'($urandom_range(0, 15)), 1'b0, pick_gap());
        // fill up to sixteen entries, then one append too many gets dropped
        for (int p = 0; p < 13; p++)
            issue_beat(FN_READY, t_port'(p + 1), 1'(p % 2), pick_gap());
        issue_beat(FN_READY, 4'd5, 1'b0, pick_gap());

        // Sender pause: let the core go fully idle before random traffic.
        drain_results();

        // ---------------- random beats ----------------
        // Stretches of 40 beats with their own append / release mix, so the
        // list spends time near empty, near full and in between.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: app_pct = 15;
                    1: app_pct = 50;
                    default: app_pct = 85;
                endcase
                case ($urandom_range(0, 2))
                    0: rel_pct = 0;
                    1: rel_pct = 30;
                    default: rel_pct = 70;
                endcase
                no_idle = ($urandom_range(0, 2) == 0);
            end
            if (n == N_RANDOM / 2) drain_results();
            issue_beat(($urandom_range(0, 99) < app_pct) ? FN_READY : FN_SEND,
                       t_port'($urandom_range(0, 15)),
                       $urandom_range(0, 99) < rel_pct,
                       pick_gap());
        end

        // wait out the last results, then idle for DRAIN_WAIT to catch stray strobes
        drain_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_count == 0)
            $display("tb_round_robin_ready_list_distributor_core: done, clean");
        else
            $display("tb_round_robin_ready_list_distributor_core: done, errors");
        $finish;
    end

endmodule
